FILE: rtl/core/one_bit_bitmap_fit_scaler_unit_assert.svh
// Assertion macros shared by the scaler top and divider RTL files.
`ifndef ONE_BIT_BITMAP_FIT_SCALER_UNIT_ASSERT_SVH
`define ONE_BIT_BITMAP_FIT_SCALER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define OFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define OFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ofs_pkg.sv
// Shared constants, codes and types for the 1bpp fit scaler.
`timescale 1ns / 1ps
`default_nettype none

package ofs_pkg;

    // Default sizes.
    localparam int SOURCE_BYTES_DEF = 8192;
    localparam int DIM_BITS_DEF     = 10;

    // Field widths.
    localparam int ADDR_W   = 13;
    localparam int BYTE_W   = 8;
    localparam int FIELD_W  = 10;
    localparam int COL_W    = 7;
    localparam int BIT_W    = 3;
    localparam int STATUS_W = 2;

    // Pixel packing.
    localparam int             PIX_PER_BYTE = 8;
    localparam logic [BIT_W-1:0] LAST_BIT   = 3'd7;
    localparam logic [BYTE_W-1:0] BLANK_BYTE = 8'hFF;

    // Stream word layout.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = STATUS_W;
    localparam int SA_LSB    = 0;
    localparam int SD_LSB    = SA_LSB + ADDR_W;
    localparam int DR_LSB    = SD_LSB + BYTE_W;
    localparam int DC_LSB    = DR_LSB + FIELD_W;
    localparam int M_PAD_W   = M_TDATA_W - BYTE_W - 2 * FIELD_W;

    // Commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

    // Register indexes.
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_SRC_W = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_H = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOX_W = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOX_H = 2'd3;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/one_bit_bitmap_fit_scaler_unit.sv
// A byte write is taken in the idle state; a fetch is set by two passes of the serial divider,
// for the source row and then for the first source column of the byte.
// The first fetch after a register write also computes the destination size with divider
// and multiplier steps. One word is worked on at a time.
// Reset (synchronous, active low) clears the sequencer, the size cache, the registers to zero
// and the output valid; the source store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "one_bit_bitmap_fit_scaler_unit_assert.svh"

module one_bit_bitmap_fit_scaler_unit #(
    parameter int SOURCE_BYTES = ofs_pkg::SOURCE_BYTES_DEF,
    parameter int DIM_BITS     = ofs_pkg::DIM_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Register write port
    input  logic                          cfg_we,
    input  logic [ofs_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]           cfg_wdata,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // source_address[12:0], source_data[20:13], dest_row[30:21], dest_byte_column[37:31]
    input  logic [ofs_pkg::S_TDATA_W-1:0] s_tdata,
    // command[0]
    input  logic [ofs_pkg::S_TUSER_W-1:0] s_tuser,
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // dest_data[7:0], dest_width[17:8], dest_height[27:18]
    output logic [ofs_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [ofs_pkg::M_TUSER_W-1:0] m_tuser
);
    import ofs_pkg::*;

    localparam int AW   = $clog2(SOURCE_BYTES);
    localparam int XW   = (DIM_BITS > FIELD_W) ? DIM_BITS : FIELD_W;
    localparam int NW   = XW + DIM_BITS;
    localparam int STW  = DIM_BITS - 2;
    localparam int RBW  = DIM_BITS + STW;
    localparam int IDXW = (RBW + 1 > AW + 1) ? RBW + 1 : AW + 1;
    localparam int CMPW = (NW > AW + 1) ? NW : AW + 1;
    localparam int AW1  = (AW + 1 > ADDR_W) ? AW + 1 : ADDR_W;
    localparam int CCW  = (STW > COL_W) ? STW : COL_W;

    // Sequencer states.
    localparam int SW = 5;
    localparam logic [SW-1:0] S_IDLE      = 5'd0;
    localparam logic [SW-1:0] S_DIMS_MUL  = 5'd1;
    localparam logic [SW-1:0] S_DIMS_CHK  = 5'd2;
    localparam logic [SW-1:0] S_KX_WAIT   = 5'd3;
    localparam logic [SW-1:0] S_KY_WAIT   = 5'd4;
    localparam logic [SW-1:0] S_FIT_H     = 5'd5;
    localparam logic [SW-1:0] S_FIT_END   = 5'd6;
    localparam logic [SW-1:0] S_H_DIV     = 5'd7;
    localparam logic [SW-1:0] S_H_WAIT    = 5'd8;
    localparam logic [SW-1:0] S_W_DIV     = 5'd9;
    localparam logic [SW-1:0] S_W_WAIT    = 5'd10;
    localparam logic [SW-1:0] S_DIMS_END  = 5'd11;
    localparam logic [SW-1:0] S_STEP_WAIT = 5'd12;
    localparam logic [SW-1:0] S_FETCH     = 5'd13;
    localparam logic [SW-1:0] S_SY_DIV    = 5'd14;
    localparam logic [SW-1:0] S_SY_WAIT   = 5'd15;
    localparam logic [SW-1:0] S_X0_MUL    = 5'd16;
    localparam logic [SW-1:0] S_X0_DIV    = 5'd17;
    localparam logic [SW-1:0] S_X0_WAIT   = 5'd18;
    localparam logic [SW-1:0] S_PIX_RD    = 5'd19;
    localparam logic [SW-1:0] S_PIX_USE   = 5'd20;
    localparam logic [SW-1:0] S_EMIT      = 5'd21;

    // Configuration registers.
    logic [DIM_BITS-1:0] sw_reg, sh_reg, bw_reg, bh_reg;

    // Sequencer and datapath registers.
    logic [SW-1:0]       state_reg, state_next;
    logic                dims_valid_reg, dims_valid_next;
    logic                dims_ok_reg, dims_ok_next;
    logic [DIM_BITS-1:0] dw_reg, dw_next;
    logic [DIM_BITS-1:0] dh_reg, dh_next;
    logic [DIM_BITS-1:0] kx_reg, kx_next;
    logic [DIM_BITS-1:0] qs_reg, qs_next;
    logic [DIM_BITS-1:0] rs_reg, rs_next;
    logic [RBW-1:0]      rowbase_reg, rowbase_next;
    logic [DIM_BITS-1:0] sx_reg, sx_next;
    logic [DIM_BITS-1:0] rx_reg, rx_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [BIT_W-1:0]    rd_bit_reg, rd_bit_next;
    logic [BYTE_W-1:0]   data_reg, data_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FIELD_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [NW-1:0]       prod_reg;

    // Result word register.
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_data_reg, m_data_next;
    logic [FIELD_W-1:0]  m_w_reg, m_w_next;
    logic [FIELD_W-1:0]  m_h_reg, m_h_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;

    // Shared multiplier operands.
    logic                mul_en;
    logic [XW-1:0]       mul_a;
    logic [DIM_BITS-1:0] mul_b;

    // Shared divider connections.
    logic                div_start;
    logic [NW-1:0]       div_num;
    logic [DIM_BITS-1:0] div_den;
    logic [NW-1:0]       div_quo;
    logic [DIM_BITS-1:0] div_rem;
    div_stat_t           div_stat;

    // Store connections.
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [BYTE_W-1:0]   mem_rdata;

    // Input word fields.
    logic                in_cmd;
    logic [ADDR_W-1:0]   in_addr;
    logic [BYTE_W-1:0]   in_data;
    logic [FIELD_W-1:0]  in_row;
    logic [COL_W-1:0]    in_col;

    // Derived values.
    logic [DIM_BITS:0]   sw_pad, dw_pad, rsum, rdiff;
    logic [STW-1:0]      stride, dcols;
    logic                rstep;
    logic [IDXW-1:0]     pix_idx;
    logic [FIELD_W-1:0]  pix_dx;
    logic                pix_in_row;
    logic                pix_in_store;
    logic [DIM_BITS-1:0] ky_q, k_min;

    assign in_cmd  = s_tuser[0];
    assign in_addr = s_tdata[SA_LSB +: ADDR_W];
    assign in_data = s_tdata[SD_LSB +: BYTE_W];
    assign in_row  = s_tdata[DR_LSB +: FIELD_W];
    assign in_col  = s_tdata[DC_LSB +: COL_W];

    // Padded row length of the source and byte columns of the destination.
    assign sw_pad = {1'b0, sw_reg} + (DIM_BITS + 1)'(PIX_PER_BYTE - 1);
    assign dw_pad = {1'b0, dw_reg} + (DIM_BITS + 1)'(PIX_PER_BYTE - 1);
    assign stride = sw_pad[DIM_BITS:3];
    assign dcols  = dw_pad[DIM_BITS:3];

    // Incremental source column step: sx advances by sw/dw with remainder carry.
    assign rsum  = {1'b0, rx_reg} + {1'b0, rs_reg};
    assign rstep = (rsum >= {1'b0, dw_reg});
    assign rdiff = rsum - {1'b0, dw_reg};

    // Current pixel position and its source byte.
    assign pix_dx       = {col_reg, bit_reg};
    assign pix_in_row   = (XW'(pix_dx) < XW'(dw_reg));
    assign pix_idx      = IDXW'(rowbase_reg) + IDXW'(sx_reg[DIM_BITS-1:3]);
    assign pix_in_store = (pix_idx < IDXW'(SOURCE_BYTES));

    // Smaller of the two whole enlargement factors.
    assign ky_q  = div_quo[DIM_BITS-1:0];
    assign k_min = (ky_q < kx_reg) ? ky_q : kx_reg;

    assign s_tready = (state_reg == S_IDLE);

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        dims_valid_next = dims_valid_reg;
        dims_ok_next    = dims_ok_reg;
        dw_next         = dw_reg;
        dh_next         = dh_reg;
        kx_next         = kx_reg;
        qs_next         = qs_reg;
        rs_next         = rs_reg;
        rowbase_next    = rowbase_reg;
        sx_next         = sx_reg;
        rx_next         = rx_reg;
        bit_next        = bit_reg;
        rd_pend_next    = rd_pend_reg;
        rd_bit_next     = rd_bit_reg;
        data_next       = data_reg;
        status_next     = status_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_w_next        = m_w_reg;
        m_h_next        = m_h_reg;
        m_status_next   = m_status_reg;
        mul_en          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        div_start       = 1'b0;
        div_num         = '0;
        div_den         = '0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = pix_idx[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (in_cmd == CMD_WRITE) begin
                        mem_we = (AW1'(in_addr) < AW1'(SOURCE_BYTES));
                    end else begin
                        row_next   = in_row;
                        col_next   = in_col;
                        state_next = dims_valid_reg ? S_FETCH : S_DIMS_MUL;
                    end
                end
            end

            // Source size check: height times padded row length.
            S_DIMS_MUL: begin
                mul_en     = 1'b1;
                mul_a      = XW'(sh_reg);
                mul_b      = DIM_BITS'(stride);
                state_next = S_DIMS_CHK;
            end

            S_DIMS_CHK: begin
                if (sw_reg == '0 || sh_reg == '0 ||
                    CMPW'(prod_reg) > CMPW'(SOURCE_BYTES)) begin
                    dims_ok_next    = 1'b0;
                    dims_valid_next = 1'b1;
                    state_next      = S_FETCH;
                end else if (sw_reg <= bw_reg && sh_reg <= bh_reg) begin
                    div_start  = 1'b1;
                    div_num    = NW'(bw_reg);
                    div_den    = sw_reg;
                    state_next = S_KX_WAIT;
                end else begin
                    mul_en     = 1'b1;
                    mul_a      = XW'(sh_reg);
                    mul_b      = bw_reg;
                    state_next = S_H_DIV;
                end
            end

            // Enlarge: k = min(bw/sw, bh/sh).
            S_KX_WAIT: begin
                if (div_stat.done) begin
                    kx_next    = div_quo[DIM_BITS-1:0];
                    div_start  = 1'b1;
                    div_num    = NW'(bh_reg);
                    div_den    = sh_reg;
                    state_next = S_KY_WAIT;
                end
            end

            S_KY_WAIT: begin
                if (div_stat.done) begin
                    kx_next    = k_min;
                    mul_en     = 1'b1;
                    mul_a      = XW'(k_min);
                    mul_b      = sw_reg;
                    state_next = S_FIT_H;
                end
            end

            S_FIT_H: begin
                dw_next    = prod_reg[DIM_BITS-1:0];
                mul_en     = 1'b1;
                mul_a      = XW'(kx_reg);
                mul_b      = sh_reg;
                state_next = S_FIT_END;
            end

            S_FIT_END: begin
                dh_next    = prod_reg[DIM_BITS-1:0];
                state_next = S_DIMS_END;
            end

            // Shrink to the box width, or to the box height if that is exceeded.
            S_H_DIV: begin
                div_start  = 1'b1;
                div_num    = prod_reg;
                div_den    = sw_reg;
                state_next = S_H_WAIT;
            end

            S_H_WAIT: begin
                if (div_stat.done) begin
                    if (div_quo > NW'(bh_reg)) begin
                        dh_next    = bh_reg;
                        mul_en     = 1'b1;
                        mul_a      = XW'(sw_reg);
                        mul_b      = bh_reg;
                        state_next = S_W_DIV;
                    end else begin
                        dh_next    = div_quo[DIM_BITS-1:0];
                        dw_next    = bw_reg;
                        state_next = S_DIMS_END;
                    end
                end
            end

            S_W_DIV: begin
                div_start  = 1'b1;
                div_num    = prod_reg;
                div_den    = sh_reg;
                state_next = S_W_WAIT;
            end

            S_W_WAIT: begin
                if (div_stat.done) begin
                    dw_next    = div_quo[DIM_BITS-1:0];
                    state_next = S_DIMS_END;
                end
            end

            // Reject an empty result, else precompute the column step sw/dw.
            S_DIMS_END: begin
                if (dw_reg == '0 || dh_reg == '0) begin
                    dims_ok_next    = 1'b0;
                    dims_valid_next = 1'b1;
                    state_next      = S_FETCH;
                end else begin
                    div_start  = 1'b1;
                    div_num    = NW'(sw_reg);
                    div_den    = dw_reg;
                    state_next = S_STEP_WAIT;
                end
            end

            S_STEP_WAIT: begin
                if (div_stat.done) begin
                    qs_next         = div_quo[DIM_BITS-1:0];
                    rs_next         = div_rem;
                    dims_ok_next    = 1'b1;
                    dims_valid_next = 1'b1;
                    state_next      = S_FETCH;
                end
            end

            // Fetch: range checks, then source row sy = row*sh/dh.
            S_FETCH: begin
                data_next = BLANK_BYTE;
                bit_next  = '0;
                if (!dims_ok_reg) begin
                    status_next = ST_INVALID;
                    state_next  = S_EMIT;
                end else if (XW'(row_reg) >= XW'(dh_reg) ||
                             CCW'(col_reg) >= CCW'(dcols)) begin
                    status_next = ST_OUTSIDE;
                    state_next  = S_EMIT;
                end else begin
                    status_next = ST_OK;
                    mul_en      = 1'b1;
                    mul_a       = XW'(row_reg);
                    mul_b       = sh_reg;
                    state_next  = S_SY_DIV;
                end
            end

            S_SY_DIV: begin
                div_start  = 1'b1;
                div_num    = prod_reg;
                div_den    = dh_reg;
                state_next = S_SY_WAIT;
            end

            S_SY_WAIT: begin
                if (div_stat.done) begin
                    mul_en     = 1'b1;
                    mul_a      = XW'(div_quo[DIM_BITS-1:0]);
                    mul_b      = DIM_BITS'(stride);
                    state_next = S_X0_MUL;
                end
            end

            // First source column of the byte: sx = col*8*sw/dw.
            S_X0_MUL: begin
                rowbase_next = prod_reg[RBW-1:0];
                mul_en       = 1'b1;
                mul_a        = XW'({col_reg, {BIT_W{1'b0}}});
                mul_b        = sw_reg;
                state_next   = S_X0_DIV;
            end

            S_X0_DIV: begin
                div_start  = 1'b1;
                div_num    = prod_reg;
                div_den    = dw_reg;
                state_next = S_X0_WAIT;
            end

            S_X0_WAIT: begin
                if (div_stat.done) begin
                    sx_next    = div_quo[DIM_BITS-1:0];
                    rx_next    = div_rem;
                    state_next = S_PIX_RD;
                end
            end

            // Read the source byte of this pixel and step to the next column.
            S_PIX_RD: begin
                rd_pend_next = pix_in_row && pix_in_store;
                mem_re       = pix_in_row && pix_in_store;
                rd_bit_next  = sx_reg[BIT_W-1:0];
                if (rstep) begin
                    rx_next = rdiff[DIM_BITS-1:0];
                end else begin
                    rx_next = rsum[DIM_BITS-1:0];
                end
                sx_next    = sx_reg + qs_reg + DIM_BITS'(rstep);
                state_next = S_PIX_USE;
            end

            // A dark source pixel clears the matching destination bit.
            S_PIX_USE: begin
                if (rd_pend_reg && !mem_rdata[LAST_BIT - rd_bit_reg]) begin
                    data_next[LAST_BIT - bit_reg] = 1'b0;
                end
                if (bit_reg == LAST_BIT) begin
                    state_next = S_EMIT;
                end else begin
                    bit_next   = bit_reg + 1'b1;
                    state_next = S_PIX_RD;
                end
            end

            // Hand the result to the output register once it is free.
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = data_reg;
                    m_w_next      = dims_ok_reg ? FIELD_W'(dw_reg) : '0;
                    m_h_next      = dims_ok_reg ? FIELD_W'(dh_reg) : '0;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration registers; a write drops the cached destination size.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= '0;
            sh_reg <= '0;
            bw_reg <= '0;
            bh_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SRC_W: sw_reg <= cfg_wdata;
                REG_SRC_H: sh_reg <= cfg_wdata;
                REG_BOX_W: bw_reg <= cfg_wdata;
                REG_BOX_H: bh_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            dims_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            dims_valid_reg <= cfg_we ? 1'b0 : dims_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        dims_ok_reg  <= dims_ok_next;
        dw_reg       <= dw_next;
        dh_reg       <= dh_next;
        kx_reg       <= kx_next;
        qs_reg       <= qs_next;
        rs_reg       <= rs_next;
        rowbase_reg  <= rowbase_next;
        sx_reg       <= sx_next;
        rx_reg       <= rx_next;
        bit_reg      <= bit_next;
        rd_pend_reg  <= rd_pend_next;
        rd_bit_reg   <= rd_bit_next;
        data_reg     <= data_next;
        status_reg   <= status_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        m_data_reg   <= m_data_next;
        m_w_reg      <= m_w_next;
        m_h_reg      <= m_h_next;
        m_status_reg <= m_status_next;
    end

    // Shared multiplier, product registered.
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= NW'(mul_a) * NW'(mul_b);
        end
    end

    ofs_div #(
        .NUM_W (NW),
        .DEN_W (DIM_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .rem     (div_rem),
        .stat    (div_stat)
    );

    ofs_store #(
        .DEPTH (SOURCE_BYTES),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (AW'(in_addr)),
        .wdata (in_data),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_h_reg, m_w_reg, m_data_reg};
    assign m_tuser  = m_status_reg;

    // The divider is never left running while a new word can be taken.
    `OFS_ASSERT_IMP(a_idle_div_free, s_tready, !div_stat.busy, "divider busy in idle")
    // An invalid-size result carries a blank byte and zero sizes.
    `OFS_ASSERT_IMP(a_invalid_blank, m_valid_reg && m_status_reg == ST_INVALID,
        m_data_reg == BLANK_BYTE && m_w_reg == '0 && m_h_reg == '0, "bad invalid result")
    // Leaving the emit state always presents a result word.
    `OFS_ASSERT_NXT(a_emit_loads, state_reg == S_EMIT && (!m_valid_reg || m_tready),
        m_valid_reg && state_reg == S_IDLE, "emit did not load result")

endmodule

`default_nettype wire

FILE: rtl/core/ofs_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "one_bit_bitmap_fit_scaler_unit_assert.svh"

module ofs_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output logic [NUM_W-1:0]      quo,
    output logic [DEN_W-1:0]      rem,
    output ofs_pkg::div_stat_t    stat
);
    import ofs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    // Iteration control.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo       = quo_reg;
    assign rem       = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // A new division starts only once the previous one has finished.
    `OFS_ASSERT_IMP(a_div_start_idle, start, !busy_reg, "divider started while busy")
    // The partial remainder always stays below the divisor.
    `OFS_ASSERT_IMP(a_div_rem_bound, busy_reg, rem_reg < den_reg, "remainder out of range")

endmodule

`default_nettype wire

FILE: rtl/core/ofs_store.sv
// Source bitmap byte store with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ofs_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [ofs_pkg::BYTE_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [ofs_pkg::BYTE_W-1:0] rdata
);
    import ofs_pkg::*;

    logic [BYTE_W-1:0] mem_reg [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data registered.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
